// ----- design/kpc_pkg.sv -----
// Shared types, constants and the per-key hold/release rule.
`timescale 1ns / 1ps
package kpc_pkg;

	localparam int CNT_W       = 8;
	localparam int EV_W        = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;
	localparam int S_DATA_W    = 8;
	localparam int M_DATA_W    = 16;

	localparam logic [CNT_W-1:0] LONG_RESET   = 8'd25;
	localparam logic [CNT_W-1:0] REPEAT_RESET = 8'd35;

	typedef enum logic [EV_W-1:0] {
		EV_NONE    = 3'd0,
		EV_SHORT_1 = 3'd1,
		EV_SHORT_2 = 3'd2,
		EV_LONG_1  = 3'd3,
		EV_LONG_2  = 3'd4,
		EV_REP_1   = 3'd5,
		EV_REP_2   = 3'd6
	} kpc_event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LONG_PRESS   = 1'b0,
		REG_REPEAT_LIMIT = 1'b1
	} kpc_reg_t;

	// bit0 = newest sample, bit1 = previous
	typedef struct packed {
		logic [1:0]       k1_smp;
		logic [1:0]       k2_smp;
		logic [CNT_W-1:0] cnt;
		kpc_event_t       ev;
	} kpc_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] long_ticks;
		logic [CNT_W-1:0] rep_ticks;
	} kpc_cfg_t;

	// Hold/release rule for one key against the shared counter and latch.
	function automatic kpc_state_t key_rule(
		input kpc_state_t st,
		input logic [1:0] hist,
		input kpc_cfg_t   cfg,
		input kpc_event_t short_ev,
		input kpc_event_t long_ev,
		input kpc_event_t rep_ev
	);
		kpc_state_t     r;
		logic [CNT_W:0] nxt;
		r   = st;
		nxt = {1'b0, st.cnt} + {{CNT_W{1'b0}}, 1'b1};
		if (hist == 2'b00) begin
			if (nxt == {1'b0, cfg.long_ticks}) begin
				r.cnt = nxt[CNT_W-1:0];
				r.ev  = long_ev;
			end else if (nxt > {1'b0, cfg.rep_ticks}) begin
				r.cnt = cfg.rep_ticks;
				r.ev  = rep_ev;
			end else begin
				r.cnt = nxt[CNT_W-1:0];
			end
		end else if (hist == 2'b01) begin
			// release edge
			if (st.cnt < cfg.long_ticks) r.ev = short_ev;
			r.cnt = '0;
		end
		return r;
	endfunction

endpackage

// ----- design/kpc_step.sv -----
// Next-state logic for one word: scan tick or read-and-clear.
`timescale 1ns / 1ps
module kpc_step (
	input  kpc_pkg::kpc_state_t st,
	input  kpc_pkg::kpc_cfg_t   cfg,
	input  logic                func,
	input  logic                key1_level,
	input  logic                key2_level,
	output kpc_pkg::kpc_state_t st_next,
	output kpc_pkg::kpc_event_t event_code
);
	import kpc_pkg::*;

	kpc_state_t shifted;
	kpc_state_t after1;
	kpc_state_t after2;

	always_comb begin
		shifted        = st;
		shifted.k1_smp = {st.k1_smp[0], key1_level};
		shifted.k2_smp = {st.k2_smp[0], key2_level};

		after1 = shifted;
		if (shifted.k2_smp[0])
			after1 = key_rule(shifted, shifted.k1_smp, cfg, EV_SHORT_1, EV_LONG_1, EV_REP_1);

		// key 2 rule sees what the key 1 rule left
		after2 = after1;
		if (after1.k1_smp[0])
			after2 = key_rule(after1, after1.k2_smp, cfg, EV_SHORT_2, EV_LONG_2, EV_REP_2);

		if (func) begin
			st_next    = st;
			st_next.ev = EV_NONE;
			event_code = st.ev;
		end else begin
			st_next    = after2;
			event_code = after2.ev;
		end
	end

endmodule

// ----- design/two_key_press_classifier_core.sv -----
// Top level: input register, key state, config registers and result register.
//
//  channel | dir | handshake                | payload
//  s_*     | in  | s_tvalid / s_tready      | tuser: func; tdata: key1_level, key2_level
//  m_*     | out | m_tvalid / m_tready      | tdata: event_code, hold_count
//  cfg_*   | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One word per cycle sustained while m_tready is high; the result word passes the
// input register, then the rule logic into the state and result registers.
// Reset: keys released, counter zero, no event, thresholds 25 and 35.
// A stalled result holds the pipe; the input register still takes a word when it
// is empty or the result register is empty or being drained. Config is always ready.
`timescale 1ns / 1ps
module two_key_press_classifier_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [kpc_pkg::S_DATA_W-1:0]     s_tdata,   // [0] key1_level, [1] key2_level
	input  logic                             s_tuser,   // [0] func
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [kpc_pkg::M_DATA_W-1:0]     m_tdata,   // [2:0] event_code, [10:3] hold_count
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import kpc_pkg::*;

	logic             valid_s1;
	logic             func_s1;
	logic             key1_s1;
	logic             key2_s1;
	logic             out_valid_q;
	logic [EV_W-1:0]  out_ev_q;
	logic [CNT_W-1:0] out_cnt_q;
	kpc_state_t       state_q;
	kpc_state_t       state_next;
	kpc_event_t       ev_next;
	kpc_cfg_t         cfg_q;
	logic             advance;
	logic             fire;

	assign advance   = !out_valid_q || m_tready;
	assign fire      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_ticks <= LONG_RESET;
			cfg_q.rep_ticks  <= REPEAT_RESET;
		end else if (cfg_valid) begin
			unique case (kpc_reg_t'(cfg_index))
				REG_LONG_PRESS:   cfg_q.long_ticks <= cfg_data;
				REG_REPEAT_LIMIT: cfg_q.rep_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			key1_s1 <= s_tdata[0];
			key2_s1 <= s_tdata[1];
		end
	end

	kpc_step u_step (
		.st         (state_q),
		.cfg        (cfg_q),
		.func       (func_s1),
		.key1_level (key1_s1),
		.key2_level (key2_s1),
		.st_next    (state_next),
		.event_code (ev_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.k1_smp <= 2'b11;
			state_q.k2_smp <= 2'b11;
			state_q.cnt    <= '0;
			state_q.ev     <= EV_NONE;
			out_valid_q    <= 1'b0;
		end else begin
			if (fire) state_q <= state_next;
			if (fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_ev_q  <= ev_next;
			out_cnt_q <= state_next.cnt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W - EV_W - CNT_W){1'b0}}, out_cnt_q, out_ev_q};

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && func_s1 |=> state_q.ev == EV_NONE)
		else $error("read did not clear latched event");

	a_read_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && func_s1 |=> $stable(state_q.cnt) && $stable(state_q.k1_smp)
			&& $stable(state_q.k2_smp))
		else $error("read changed counter or samples");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1))
		else $error("result word without an item");

	a_state_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(state_q))
		else $error("key state moved without an item");

	a_both_pressed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !func_s1 && !key1_s1 && !key2_s1 |=> $stable(state_q.cnt))
		else $error("counter moved with both keys pressed");

endmodule
